// ===== rtl/core/mco_pkg.sv =====
// Shared types, codes and the control store for the matrix chain order block.
package mco_pkg;

    // Fixed field widths of the item and result payloads
    localparam int COST_W  = 56;
    localparam int SPLIT_W = 4;
    localparam int FDIM_W  = 16;
    localparam int QIDX_W  = 5;
    localparam int STEP_W  = 5;

    // Saturation ceiling for costs
    localparam logic [COST_W-1:0] COST_MAX = '1;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    // Control store addresses
    localparam logic [STEP_W-1:0] S_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] S_DISP  = 5'd1;
    localparam logic [STEP_W-1:0] S_CHK   = 5'd2;
    localparam logic [STEP_W-1:0] S_DINIT = 5'd3;
    localparam logic [STEP_W-1:0] S_DIAG  = 5'd4;
    localparam logic [STEP_W-1:0] S_LINIT = 5'd5;
    localparam logic [STEP_W-1:0] S_ROW   = 5'd6;
    localparam logic [STEP_W-1:0] S_KA    = 5'd7;
    localparam logic [STEP_W-1:0] S_KB    = 5'd8;
    localparam logic [STEP_W-1:0] S_KC    = 5'd9;
    localparam logic [STEP_W-1:0] S_KD    = 5'd10;
    localparam logic [STEP_W-1:0] S_KE    = 5'd11;
    localparam logic [STEP_W-1:0] S_KF    = 5'd12;
    localparam logic [STEP_W-1:0] S_WRB   = 5'd13;
    localparam logic [STEP_W-1:0] S_NLEN  = 5'd14;
    localparam logic [STEP_W-1:0] S_RD    = 5'd15;
    localparam logic [STEP_W-1:0] S_OUT   = 5'd16;

    typedef struct packed {
        logic              kind;
        logic [FDIM_W-1:0] dim_value;
        logic              last_dim;
        logic [QIDX_W-1:0] query_row;
        logic [QIDX_W-1:0] query_col;
    } item_t;

    typedef struct packed {
        logic [COST_W-1:0]  min_cost;
        logic [SPLIT_W-1:0] best_split;
        logic [1:0]         status;
    } result_t;

    // Datapath operation of one control word
    typedef enum logic [3:0] {
        OP_NONE,
        OP_WAIT,
        OP_DIAG_INIT,
        OP_DIAG_WR,
        OP_LEN_INIT,
        OP_ROW_INIT,
        OP_LAT_A,
        OP_LAT_B,
        OP_LAT_C,
        OP_MUL2,
        OP_CMP,
        OP_WR_BEST,
        OP_LEN_NEXT,
        OP_OUT
    } op_t;

    // Dimension store read address select
    typedef enum logic [1:0] {
        D_NONE,
        D_IM1,
        D_K,
        D_J
    } dsel_t;

    // Cost store read address select
    typedef enum logic [1:0] {
        CS_NONE,
        CS_IK,
        CS_KJ,
        CS_RES
    } csel_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_WORK,
        C_QUERY,
        C_LOAD_ERR,
        C_DIAG_MORE,
        C_N_LT2,
        C_K_MORE,
        C_ROW_MORE,
        C_LEN_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        dsel_t             dsel;
        csel_t             csel;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              home;
    } ctrl_t;

    typedef struct packed {
        logic no_work;
        logic is_query;
        logic load_err;
        logic diag_more;
        logic n_lt2;
        logic k_more;
        logic row_more;
        logic len_more;
        logic out_busy;
    } flags_t;

    // Pack one control word
    function automatic ctrl_t cw(op_t op, dsel_t ds, csel_t cs, cond_t cd,
                                 logic [STEP_W-1:0] tg, logic hm);
        ctrl_t w;
        w.op     = op;
        w.dsel   = ds;
        w.csel   = cs;
        w.cond   = cd;
        w.target = tg;
        w.home   = hm;
        return w;
    endfunction

    // Control store: one word per step
    function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
        ctrl_t w;
        unique case (step)
            S_IDLE:  w = cw(OP_WAIT,      D_NONE, CS_NONE, C_NO_WORK,   S_IDLE, 1'b0);
            S_DISP:  w = cw(OP_NONE,      D_NONE, CS_NONE, C_QUERY,     S_RD,   1'b0);
            S_CHK:   w = cw(OP_NONE,      D_NONE, CS_NONE, C_LOAD_ERR,  S_OUT,  1'b0);
            S_DINIT: w = cw(OP_DIAG_INIT, D_NONE, CS_NONE, C_NEXT,      S_IDLE, 1'b0);
            S_DIAG:  w = cw(OP_DIAG_WR,   D_NONE, CS_NONE, C_DIAG_MORE, S_DIAG, 1'b0);
            S_LINIT: w = cw(OP_LEN_INIT,  D_NONE, CS_NONE, C_N_LT2,     S_RD,   1'b0);
            S_ROW:   w = cw(OP_ROW_INIT,  D_NONE, CS_NONE, C_NEXT,      S_IDLE, 1'b0);
            S_KA:    w = cw(OP_NONE,      D_IM1,  CS_IK,   C_NEXT,      S_IDLE, 1'b0);
            S_KB:    w = cw(OP_LAT_A,     D_K,    CS_KJ,   C_NEXT,      S_IDLE, 1'b0);
            S_KC:    w = cw(OP_LAT_B,     D_J,    CS_NONE, C_NEXT,      S_IDLE, 1'b0);
            S_KD:    w = cw(OP_LAT_C,     D_NONE, CS_NONE, C_NEXT,      S_IDLE, 1'b0);
            S_KE:    w = cw(OP_MUL2,      D_NONE, CS_NONE, C_NEXT,      S_IDLE, 1'b0);
            S_KF:    w = cw(OP_CMP,       D_NONE, CS_NONE, C_K_MORE,    S_KA,   1'b0);
            S_WRB:   w = cw(OP_WR_BEST,   D_NONE, CS_NONE, C_ROW_MORE,  S_ROW,  1'b0);
            S_NLEN:  w = cw(OP_LEN_NEXT,  D_NONE, CS_NONE, C_LEN_MORE,  S_ROW,  1'b0);
            S_RD:    w = cw(OP_NONE,      D_NONE, CS_RES,  C_NEXT,      S_IDLE, 1'b0);
            S_OUT:   w = cw(OP_OUT,       D_NONE, CS_NONE, C_OUT_BUSY,  S_OUT,  1'b1);
            default: w = cw(OP_NONE,      D_NONE, CS_NONE, C_ALWAYS,    S_IDLE, 1'b0);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/mco_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mco_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mco_seq.sv =====
// Microcode sequencer: step counter, control store fetch and conditional jumps.
module mco_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  mco_pkg::flags_t flags,
    output mco_pkg::ctrl_t  ctrl
);

    logic [mco_pkg::STEP_W-1:0] step_reg;
    logic [mco_pkg::STEP_W-1:0] step_next;
    logic                       take;

    // Fetch the current control word
    assign ctrl = mco_pkg::ucode(step_reg);

    // Evaluate the jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            mco_pkg::C_NEXT:      take = 1'b0;
            mco_pkg::C_ALWAYS:    take = 1'b1;
            mco_pkg::C_NO_WORK:   take = flags.no_work;
            mco_pkg::C_QUERY:     take = flags.is_query;
            mco_pkg::C_LOAD_ERR:  take = flags.load_err;
            mco_pkg::C_DIAG_MORE: take = flags.diag_more;
            mco_pkg::C_N_LT2:     take = flags.n_lt2;
            mco_pkg::C_K_MORE:    take = flags.k_more;
            mco_pkg::C_ROW_MORE:  take = flags.row_more;
            mco_pkg::C_LEN_MORE:  take = flags.len_more;
            mco_pkg::C_OUT_BUSY:  take = flags.out_busy;
            default:              take = 1'b0;
        endcase
    end

    // Jump, return home, or advance
    always_comb
    begin
        priority if (take)
        begin
            step_next = ctrl.target;
        end
        else if (ctrl.home)
        begin
            step_next = mco_pkg::S_IDLE;
        end
        else
        begin
            step_next = step_reg + mco_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= mco_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/core/mco_datapath.sv =====
// Datapath: chain load bookkeeping, index counters, stores and cost arithmetic.
module mco_datapath #(
    parameter int MAX_MATRICES = 16,
    parameter int DIM_WIDTH    = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_acc,
    input  mco_pkg::item_t   item,
    input  mco_pkg::ctrl_t   ctrl,
    input  logic             out_busy,
    output mco_pkg::flags_t  flags,
    output mco_pkg::result_t res
);

    localparam int SW     = (DIM_WIDTH < mco_pkg::FDIM_W) ? DIM_WIDTH : mco_pkg::FDIM_W;
    localparam int NW     = $clog2(MAX_MATRICES + 1);
    localparam int IW     = $clog2(MAX_MATRICES);
    localparam int DAW    = $clog2(MAX_MATRICES + 1);
    localparam int CW     = $clog2(MAX_MATRICES + 2);
    localparam int XW     = (NW > mco_pkg::QIDX_W) ? NW : mco_pkg::QIDX_W;
    localparam int CDEPTH = 1 << (2 * IW);
    localparam int P1W    = 2 * SW;
    localparam int P2W    = 3 * SW;
    localparam int CW56   = mco_pkg::COST_W;

    // Chain bookkeeping (control state)
    logic [CW-1:0] dim_count_reg;
    logic          ovf_reg;
    logic          chain_ready_reg;

    // Item context and loop indices
    logic [NW-1:0]     n_reg;
    logic [1:0]        status_reg;
    logic              query_reg;
    logic [2*IW-1:0]   res_addr_reg;
    logic              res_diag_reg;
    logic [NW-1:0]     i_reg;
    logic [NW-1:0]     j_reg;
    logic [NW-1:0]     k_reg;
    logic [NW-1:0]     len_reg;

    // Arithmetic registers
    logic [SW-1:0]   pa_reg;
    logic [SW-1:0]   pb_reg;
    logic [SW-1:0]   pc_reg;
    logic [P1W-1:0]  prod1_reg;
    logic [P2W-1:0]  prod2_reg;
    logic [CW56-1:0] acc_reg;
    logic [CW56-1:0] best_reg;
    logic [NW-1:0]   bestk_reg;

    // Load and query decode
    logic          item_load;
    logic          store;
    logic [CW-1:0] cnt_after;
    logic [NW-1:0] n_new;
    logic [1:0]    load_status;
    logic          q_bad;
    logic [NW-1:0] k_inc;

    // Store ports
    logic                      dim_we;
    logic [DAW-1:0]            dim_raddr;
    logic [SW-1:0]             dim_q;
    logic                      cost_we;
    logic [2*IW-1:0]           cost_waddr;
    logic [2*IW-1:0]           cost_raddr;
    logic [CW56-1:0]           cost_wdata;
    logic [CW56-1:0]           cost_q;
    logic [mco_pkg::SPLIT_W-1:0] split_wdata;
    logic [mco_pkg::SPLIT_W-1:0] split_q;

    // Candidate cost for the current split
    logic [CW56-1:0] cand;
    logic            take_cand;

    function automatic logic [CW56-1:0] sat_add(logic [CW56-1:0] a, logic [CW56-1:0] b);
        logic [CW56:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW56] ? mco_pkg::COST_MAX : s[CW56-1:0];
    endfunction

    // Decode the incoming item
    assign item_load   = (item.kind == mco_pkg::KIND_LOAD);
    assign store       = (dim_count_reg < CW'(MAX_MATRICES + 1));
    assign cnt_after   = dim_count_reg + CW'(store);
    assign n_new       = NW'(cnt_after - CW'(1));
    assign load_status = (ovf_reg || !store) ? mco_pkg::ST_LONG :
                         ((cnt_after < CW'(2)) ? mco_pkg::ST_BAD : mco_pkg::ST_OK);
    assign q_bad       = !chain_ready_reg
                         || (item.query_row == '0)
                         || (item.query_row > item.query_col)
                         || (XW'(item.query_col) > XW'(n_reg));
    assign k_inc       = k_reg + NW'(1);

    // Sequencer flags
    assign flags.no_work   = !item_acc || (item_load && !item.last_dim);
    assign flags.is_query  = query_reg;
    assign flags.load_err  = (status_reg != mco_pkg::ST_OK);
    assign flags.diag_more = (i_reg < n_reg);
    assign flags.n_lt2     = (n_reg < NW'(2));
    assign flags.k_more    = (k_inc != j_reg);
    assign flags.row_more  = (j_reg < n_reg);
    assign flags.len_more  = (len_reg < n_reg);
    assign flags.out_busy  = out_busy;

    // Select the dimension store read address
    always_comb
    begin
        unique case (ctrl.dsel)
            mco_pkg::D_NONE: dim_raddr = '0;
            mco_pkg::D_IM1:  dim_raddr = DAW'(i_reg - NW'(1));
            mco_pkg::D_K:    dim_raddr = DAW'(k_reg);
            mco_pkg::D_J:    dim_raddr = DAW'(j_reg);
        endcase
    end

    // Select the cost store read address
    always_comb
    begin
        unique case (ctrl.csel)
            mco_pkg::CS_NONE: cost_raddr = '0;
            mco_pkg::CS_IK:   cost_raddr = {IW'(i_reg - NW'(1)), IW'(k_reg - NW'(1))};
            mco_pkg::CS_KJ:   cost_raddr = {IW'(k_reg), IW'(j_reg - NW'(1))};
            mco_pkg::CS_RES:  cost_raddr = res_addr_reg;
        endcase
    end

    // Table writes: zero diagonal, then the best of each sub-chain
    assign dim_we      = item_acc && item_load && store;
    assign cost_we     = (ctrl.op == mco_pkg::OP_DIAG_WR) || (ctrl.op == mco_pkg::OP_WR_BEST);
    assign cost_waddr  = (ctrl.op == mco_pkg::OP_WR_BEST)
                         ? {IW'(i_reg - NW'(1)), IW'(j_reg - NW'(1))}
                         : {IW'(i_reg - NW'(1)), IW'(i_reg - NW'(1))};
    assign cost_wdata  = (ctrl.op == mco_pkg::OP_WR_BEST) ? best_reg : '0;
    assign split_wdata = (ctrl.op == mco_pkg::OP_WR_BEST) ? mco_pkg::SPLIT_W'(bestk_reg) : '0;

    // Candidate: sub-chain costs plus this split's product; strict less-than keeps smallest k
    assign cand      = sat_add(acc_reg, CW56'(prod2_reg));
    assign take_cand = (k_reg == i_reg) || (cand < best_reg);

    mco_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_MATRICES + 1)
    ) u_dim_ram (
        .clk     (clk),
        .wr_en   (dim_we),
        .wr_addr (DAW'(dim_count_reg)),
        .wr_data (SW'(item.dim_value)),
        .rd_en   (ctrl.dsel != mco_pkg::D_NONE),
        .rd_addr (dim_raddr),
        .rd_data (dim_q)
    );

    mco_ram #(
        .WIDTH (CW56),
        .DEPTH (CDEPTH)
    ) u_cost_ram (
        .clk     (clk),
        .wr_en   (cost_we),
        .wr_addr (cost_waddr),
        .wr_data (cost_wdata),
        .rd_en   (ctrl.csel != mco_pkg::CS_NONE),
        .rd_addr (cost_raddr),
        .rd_data (cost_q)
    );

    mco_ram #(
        .WIDTH (mco_pkg::SPLIT_W),
        .DEPTH (CDEPTH)
    ) u_split_ram (
        .clk     (clk),
        .wr_en   (cost_we),
        .wr_addr (cost_waddr),
        .wr_data (split_wdata),
        .rd_en   (ctrl.csel == mco_pkg::CS_RES),
        .rd_addr (res_addr_reg),
        .rd_data (split_q)
    );

    // Track the chain being loaded; drop values beyond the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg   <= '0;
            ovf_reg         <= 1'b0;
            chain_ready_reg <= 1'b0;
        end
        else if (item_acc && item_load)
        begin
            chain_ready_reg <= 1'b0;
            if (item.last_dim)
            begin
                dim_count_reg <= '0;
                ovf_reg       <= 1'b0;
            end
            else if (store)
            begin
                dim_count_reg <= cnt_after;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
        else if (ctrl.op == mco_pkg::OP_DIAG_INIT)
        begin
            chain_ready_reg <= 1'b1;
        end
    end

    // Capture item context and run the datapath operation of each step
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            query_reg <= !item_load;
            if (item_load)
            begin
                status_reg   <= load_status;
                n_reg        <= n_new;
                res_addr_reg <= {IW'(0), IW'(n_new - NW'(1))};
                res_diag_reg <= (n_new == NW'(1));
            end
            else
            begin
                status_reg   <= q_bad ? mco_pkg::ST_BAD : mco_pkg::ST_OK;
                res_addr_reg <= {IW'(item.query_row - mco_pkg::QIDX_W'(1)),
                                 IW'(item.query_col - mco_pkg::QIDX_W'(1))};
                res_diag_reg <= (item.query_row == item.query_col);
            end
        end
        unique case (ctrl.op)
            mco_pkg::OP_DIAG_INIT:
            begin
                i_reg <= NW'(1);
            end
            mco_pkg::OP_DIAG_WR:
            begin
                i_reg <= i_reg + NW'(1);
            end
            mco_pkg::OP_LEN_INIT:
            begin
                len_reg <= NW'(2);
                i_reg   <= NW'(1);
            end
            mco_pkg::OP_ROW_INIT:
            begin
                j_reg <= i_reg + len_reg - NW'(1);
                k_reg <= i_reg;
            end
            mco_pkg::OP_LAT_A:
            begin
                pa_reg  <= dim_q;
                acc_reg <= cost_q;
            end
            mco_pkg::OP_LAT_B:
            begin
                pb_reg  <= dim_q;
                acc_reg <= sat_add(acc_reg, cost_q);
            end
            mco_pkg::OP_LAT_C:
            begin
                pc_reg    <= dim_q;
                prod1_reg <= P1W'(pa_reg) * P1W'(pb_reg);
            end
            mco_pkg::OP_MUL2:
            begin
                prod2_reg <= P2W'(prod1_reg) * P2W'(pc_reg);
            end
            mco_pkg::OP_CMP:
            begin
                if (take_cand)
                begin
                    best_reg  <= cand;
                    bestk_reg <= k_reg;
                end
                k_reg <= k_inc;
            end
            mco_pkg::OP_WR_BEST:
            begin
                i_reg <= i_reg + NW'(1);
            end
            mco_pkg::OP_LEN_NEXT:
            begin
                len_reg <= len_reg + NW'(1);
                i_reg   <= NW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Result of the current item; zero payload on an error status
    assign res.status     = status_reg;
    assign res.min_cost   = (status_reg == mco_pkg::ST_OK) ? cost_q : '0;
    assign res.best_split = ((status_reg == mco_pkg::ST_OK) && !res_diag_reg) ? split_q : '0;

endmodule

// ===== rtl/core/matrix_chain_order_dp_top.sv =====
// Matrix chain order engine: top level with handshakes, result register and checks.
// Load items write one chain dimension each and leave the block idle; the load flagged last
// runs the dynamic-programming fill (unless it ends in an error) and answers with the cost
// and best split of the whole chain, and query items answer with the cost and best split
// of any sub-chain (status 1 on a bad query or with no chain, status 2 when more than
// MAX_MATRICES+1 dimensions were sent). A query passes the dispatch, read and output steps
// before its result is registered. For the last load, the fill writes the zero diagonal,
// then for each sub-chain length and row runs the inner split steps and writes the best,
// and ends with the result steps. Each split candidate runs six microcode steps, set by
// the single read port of the dimension and cost RAMs and the two-step multiply. item_ready
// is low while the fill runs. A finished result waits in the output register; the next
// answering item holds at the output step until it is taken.
module matrix_chain_order_dp_top #(
    parameter int MAX_MATRICES = 16,
    parameter int DIM_WIDTH    = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  mco_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output mco_pkg::result_t result
);

    mco_pkg::ctrl_t   ctrl;
    mco_pkg::flags_t  flags;
    mco_pkg::result_t res;
    mco_pkg::result_t result_reg;
    logic             result_valid_reg;
    logic             item_acc;
    logic             out_busy;
    logic             out_load;

    // Take items only while the sequencer waits at its idle step
    assign item_ready = (ctrl.op == mco_pkg::OP_WAIT);
    assign item_acc   = item_valid && item_ready;

    // Hold the output step while an earlier result is still waiting
    assign out_busy = result_valid_reg && !result_ready;
    assign out_load = (ctrl.op == mco_pkg::OP_OUT) && !out_busy;

    mco_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    mco_datapath #(
        .MAX_MATRICES (MAX_MATRICES),
        .DIM_WIDTH    (DIM_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_acc (item_acc),
        .item     (item),
        .ctrl     (ctrl),
        .out_busy (out_busy),
        .flags    (flags),
        .res      (res)
    );

    // Output register: load a result, drop it on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result appears only after the sequencer's output step
    a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(ctrl.op == mco_pkg::OP_OUT))
        else $error("result appeared outside the output step");

    // A plain load keeps the block idle for the next item
    a_plain_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && (item.kind == mco_pkg::KIND_LOAD) && !item.last_dim
        |=> (ctrl.op == mco_pkg::OP_WAIT))
        else $error("plain load left the idle step");

    // A query always starts sequencer work
    a_query_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && (item.kind == mco_pkg::KIND_QUERY) |=> (ctrl.op != mco_pkg::OP_WAIT))
        else $error("query did not start the sequencer");

    // An error result carries no cost and no split
    a_error_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.status != mco_pkg::ST_OK)
        |-> (result_reg.min_cost == '0) && (result_reg.best_split == '0))
        else $error("error result with nonzero payload");

endmodule

// ===== verif/tb_matrix_chain_order_dp_top.sv =====
// Testbench for the matrix chain order engine: directed table, random chains, scoreboard.
module tb_matrix_chain_order_dp_top;

    localparam int MAX_MAT       = 16;
    localparam int DIM_SLOTS     = MAX_MAT + 1;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 64;
    localparam int MAX_BIG       = 5;
    localparam int ITEM_W        = $bits(mco_pkg::item_t);
    // Worst case: ~1750 items, each with its longest gap, stall and query wait, plus five
    // 16-matrix fills and the hold; the limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [mco_pkg::COST_W-1:0] FULL_CUBE = 56'h00_FFFD_0002_FFFF;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    mco_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    mco_pkg::result_t result;

    matrix_chain_order_dp_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Chain state mirrored by the cost predictor
    logic [mco_pkg::FDIM_W-1:0]  dim_store [0:DIM_SLOTS-1];
    logic [mco_pkg::COST_W-1:0]  cost_tab  [0:MAX_MAT-1][0:MAX_MAT-1];
    logic [mco_pkg::SPLIT_W-1:0] split_tab [0:MAX_MAT-1][0:MAX_MAT-1];
    int unsigned        dim_total     = 0;
    int unsigned        chain_n       = 0;
    bit                 chain_valid   = 1'b0;
    bit                 dims_overflow = 1'b0;

    mco_pkg::result_t expected_answers [$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      cycle_count = 0;
    bit      steady      = 1'b0;
    bit      hold_req    = 1'b0;

    typedef struct {
        mco_pkg::item_t   it;
        int               reps;
        bit               typed;
        mco_pkg::result_t res;
    } plan_row_t;

    plan_row_t dir_rows [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [mco_pkg::COST_W-1:0] cost_add(logic [mco_pkg::COST_W-1:0] a,
                                                            logic [mco_pkg::COST_W-1:0] b);
        logic [mco_pkg::COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[mco_pkg::COST_W] ? mco_pkg::COST_MAX : s[mco_pkg::COST_W-1:0];
    endfunction

    function automatic logic [mco_pkg::COST_W-1:0] cost_mul(logic [mco_pkg::FDIM_W-1:0] a,
                                                            logic [mco_pkg::FDIM_W-1:0] b,
                                                            logic [mco_pkg::FDIM_W-1:0] c);
        logic [63:0] p;
        p = 64'(a) * 64'(b) * 64'(c);
        return (p > 64'(mco_pkg::COST_MAX)) ? mco_pkg::COST_MAX : p[mco_pkg::COST_W-1:0];
    endfunction

    // Fill the triangular cost and split tables for n matrices
    function automatic void fill_costs(int unsigned n);
        int unsigned len, i, j, k, best_k;
        logic [mco_pkg::COST_W-1:0] best, q;
        for (i = 0; i < n; i++)
        begin
            cost_tab[i][i]  = '0;
            split_tab[i][i] = '0;
        end
        for (len = 2; len <= n; len++)
        begin
            for (i = 1; i + len - 1 <= n; i++)
            begin
                j      = i + len - 1;
                best   = '0;
                best_k = i;
                for (k = i; k < j; k++)
                begin
                    q = cost_add(cost_tab[i-1][k-1], cost_tab[k][j-1]);
                    q = cost_add(q, cost_mul(dim_store[i-1], dim_store[k], dim_store[j]));
                    // keep the smallest split on ties
                    if (k == i || q < best)
                    begin
                        best   = q;
                        best_k = k;
                    end
                end
                cost_tab[i-1][j-1]  = best;
                split_tab[i-1][j-1] = mco_pkg::SPLIT_W'(best_k);
            end
        end
    endfunction

    // Advance the chain state by one item; return 1 when it answers
    function automatic bit chain_model_step(input mco_pkg::item_t it,
                                            output mco_pkg::result_t res);
        res = '0;
        if (it.kind == mco_pkg::KIND_LOAD)
        begin
            chain_valid = 1'b0;
            if (dim_total < DIM_SLOTS)
            begin
                dim_store[dim_total] = it.dim_value;
                dim_total++;
            end
            else
            begin
                dims_overflow = 1'b1;
            end
            if (!it.last_dim)
                return 1'b0;
            if (dims_overflow)
            begin
                res.status = mco_pkg::ST_LONG;
            end
            else if (dim_total < 2)
            begin
                res.status = mco_pkg::ST_BAD;
            end
            else
            begin
                chain_n = dim_total - 1;
                fill_costs(chain_n);
                chain_valid    = 1'b1;
                res.status     = mco_pkg::ST_OK;
                res.min_cost   = cost_tab[0][chain_n-1];
                res.best_split = (chain_n > 1) ? split_tab[0][chain_n-1] : '0;
            end
            dim_total     = 0;
            dims_overflow = 1'b0;
        end
        else
        begin
            if (!chain_valid || it.query_row < 1 || it.query_row > it.query_col ||
                it.query_col > chain_n)
            begin
                res.status = mco_pkg::ST_BAD;
            end
            else
            begin
                res.status     = mco_pkg::ST_OK;
                res.min_cost   = cost_tab[it.query_row-1][it.query_col-1];
                res.best_split = (it.query_row < it.query_col) ?
                                 split_tab[it.query_row-1][it.query_col-1] : '0;
            end
        end
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, none in steady stretches
    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [mco_pkg::FDIM_W-1:0] pick_dim();
        case ($urandom_range(3))
            0:       return mco_pkg::FDIM_W'($urandom);
            1:       return mco_pkg::FDIM_W'($urandom_range(3));
            2:       return mco_pkg::FDIM_W'($urandom_range(20, 1));
            default: return $urandom_range(1) ? '1
                                              : mco_pkg::FDIM_W'($urandom_range(65535, 60000));
        endcase
    endfunction

    function automatic mco_pkg::item_t load_item(logic [mco_pkg::FDIM_W-1:0] d, logic fin);
        mco_pkg::item_t it;
        it           = '0;
        it.kind      = mco_pkg::KIND_LOAD;
        it.dim_value = d;
        it.last_dim  = fin;
        it.query_row = mco_pkg::QIDX_W'($urandom);
        it.query_col = mco_pkg::QIDX_W'($urandom);
        return it;
    endfunction

    function automatic mco_pkg::item_t query_item(int r, int c);
        mco_pkg::item_t it;
        it           = '0;
        it.kind      = mco_pkg::KIND_QUERY;
        it.dim_value = mco_pkg::FDIM_W'($urandom);
        it.last_dim  = 1'($urandom_range(1));
        it.query_row = mco_pkg::QIDX_W'(r);
        it.query_col = mco_pkg::QIDX_W'(c);
        return it;
    endfunction

    function automatic plan_row_t plan(logic kd, logic [mco_pkg::FDIM_W-1:0] d, logic fin,
                                       int r, int c, int reps, bit typed,
                                       logic [mco_pkg::COST_W-1:0] cost,
                                       int split, logic [1:0] st);
        plan_row_t p;
        p.it.kind        = kd;
        p.it.dim_value   = d;
        p.it.last_dim    = fin;
        p.it.query_row   = mco_pkg::QIDX_W'(r);
        p.it.query_col   = mco_pkg::QIDX_W'(c);
        p.reps           = reps;
        p.typed          = typed;
        p.res.min_cost   = cost;
        p.res.best_split = mco_pkg::SPLIT_W'(split);
        p.res.status     = st;
        return p;
    endfunction

    // Offer one item, hold it until the transfer, then record what it should answer
    task automatic send_item(input mco_pkg::item_t it, input bit typed,
                             input mco_pkg::result_t typed_res);
        mco_pkg::result_t res;
        bit answers;
        int gap;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        answers = chain_model_step(it, res);
        if (answers)
            expected_answers.push_back(typed ? typed_res : res);
        items_sent++;
        gap = idle_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send(input mco_pkg::item_t it);
        send_item(it, 1'b0, '0);
    endtask

    // Drop valid and wait until every expected answer has arrived
    task automatic await_answers();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_answers.size() != 0);
    endtask

    task automatic send_queries(int n, int count);
        int q, r, c;
        for (q = 0; q < count; q++)
        begin
            if ($urandom_range(4) != 0 && n > 0)
            begin
                r = $urandom_range(n, 1);
                c = $urandom_range(n, r);
            end
            else
            begin
                r = $urandom_range(31);
                c = $urandom_range(31);
            end
            send(query_item(r, c));
        end
    endtask

    // Load a well-formed chain of n matrices, then query it
    task automatic run_chain(int n);
        int idx;
        for (idx = 0; idx <= n; idx++)
            send(load_item(pick_dim(), idx == n));
        send_queries(n, $urandom_range(8, 2));
    endtask

    // Compare one accepted answer with the oldest expectation
    task automatic check_answer(input mco_pkg::result_t got);
        mco_pkg::result_t want;
        if (expected_answers.size() == 0)
        begin
            $display("%0t: unexpected result: cost %h split %0d status %0d",
                     $time, got.min_cost, got.best_split, got.status);
            mismatches++;
        end
        else
        begin
            want = expected_answers.pop_front();
            if (got.min_cost !== want.min_cost)
            begin
                $display("%0t: min_cost expected %h, got %h", $time, want.min_cost, got.min_cost);
                mismatches++;
            end
            if (got.best_split !== want.best_split)
            begin
                $display("%0t: best_split expected %0d, got %0d",
                         $time, want.best_split, got.best_split);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                mismatches++;
            end
        end
    endtask

    // Result side: check each transfer, stall at random, honor a long hold
    initial
    begin : answer_sink
        int stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_ready === 1'b1)
            begin
                check_answer(result);
                if (stall == 0)
                    stall = idle_len();
            end
            else if (stall == 0 && $urandom_range(15) == 0)
            begin
                stall = idle_len();
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int target, pick, n, k, big, rep;
        bit held;
        mco_pkg::item_t it;
        big  = 0;
        held = 1'b0;

        // Directed table: cost typed in only where it is obvious
        // no chain after reset, last flag on a query is ignored
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 1, 1, 1, 1, '0, 0,
                                mco_pkg::ST_BAD));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '1, 1'b1, 16, 16, 1, 1, '0, 0,
                                mco_pkg::ST_BAD));
        // single dimension gives no chain
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, '1, 1'b1, 0, 0, 1, 1, '0, 0,
                                mco_pkg::ST_BAD));
        // two matrices at the largest dimensions
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, '1, 1'b0, 31, 31, 2, 0, '0, 0,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, '1, 1'b1, 0, 0, 1, 1, FULL_CUBE, 1,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 1, 1, 1, 1, '0, 0,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 2, 2, 1, 1, '0, 0,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b1, 1, 2, 1, 1, FULL_CUBE, 1,
                                mco_pkg::ST_OK));
        // bad query ranges
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 2, 1, 1, 1, '0, 0,
                                mco_pkg::ST_BAD));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 0, 2, 1, 1, '0, 0,
                                mco_pkg::ST_BAD));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 1, 3, 1, 1, '0, 0,
                                mco_pkg::ST_BAD));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 31, 31, 1, 1, '0, 0,
                                mco_pkg::ST_BAD));
        // zero dimensions, one matrix
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, '0, 1'b0, 0, 0, 1, 0, '0, 0,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, '0, 1'b1, 0, 0, 1, 1, '0, 0,
                                mco_pkg::ST_OK));
        // equal dimensions: ties keep the smallest split
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, 16'd1, 1'b0, 0, 0, 3, 0, '0, 0,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, 16'd1, 1'b1, 0, 0, 1, 0, '0, 0,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 1, 3, 1, 0, '0, 0,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 2, 3, 1, 0, '0, 0,
                                mco_pkg::ST_OK));
        // a load in progress clears the ready chain
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, 16'd5, 1'b0, 0, 0, 1, 0, '0, 0,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 1, 1, 1, 1, '0, 0,
                                mco_pkg::ST_BAD));
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, 16'd7, 1'b1, 0, 0, 1, 1, '0, 0,
                                mco_pkg::ST_OK));
        // too many dimensions, then a fresh chain after it
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, '1, 1'b1, 0, 0, DIM_SLOTS + 1, 1, '0, 0,
                                mco_pkg::ST_LONG));
        dir_rows.push_back(plan(mco_pkg::KIND_QUERY, '0, 1'b0, 1, 1, 1, 1, '0, 0,
                                mco_pkg::ST_BAD));
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, 16'd3, 1'b0, 0, 0, 2, 0, '0, 0,
                                mco_pkg::ST_OK));
        dir_rows.push_back(plan(mco_pkg::KIND_LOAD, 16'd9, 1'b1, 0, 0, 1, 0, '0, 0,
                                mco_pkg::ST_OK));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; only the final repeat keeps the last flag
        foreach (dir_rows[i])
        begin
            for (rep = 0; rep < dir_rows[i].reps; rep++)
            begin
                it = dir_rows[i].it;
                if (rep < dir_rows[i].reps - 1)
                    it.last_dim = 1'b0;
                send_item(it, dir_rows[i].typed && rep == dir_rows[i].reps - 1, dir_rows[i].res);
            end
        end
        await_answers();

        // Random part: mostly well-formed chains, some broken ones and noise
        target = items_sent + RANDOM_ITEMS;
        run_chain(MAX_MAT);
        big++;
        while (items_sent < target)
        begin
            steady = ($urandom_range(9) == 0);
            pick   = $urandom_range(99);
            if (pick < 65)
            begin
                k = $urandom_range(99);
                if (k < 3 && big < MAX_BIG)
                begin
                    n = MAX_MAT;
                    big++;
                end
                else if (k < 15)
                begin
                    n = $urandom_range(12, 6);
                end
                else
                begin
                    n = $urandom_range(5, 1);
                end
                run_chain(n);
            end
            else if (pick < 73)
            begin
                n = $urandom_range(DIM_SLOTS + 3, DIM_SLOTS + 1);
                for (k = 1; k < n; k++)
                    send(load_item(pick_dim(), 1'b0));
                send(load_item(pick_dim(), 1'b1));
                send_queries(1, 1);
            end
            else if (pick < 78)
            begin
                send(load_item(pick_dim(), 1'b1));
                send_queries(2, 1);
            end
            else if (pick < 88)
            begin
                // queries in the middle of a load find no chain
                n = $urandom_range(4, 1);
                for (k = 0; k < n; k++)
                    send(load_item(pick_dim(), 1'b0));
                send_queries(n, $urandom_range(2, 1));
                n = $urandom_range(4, 1);
                for (k = 1; k < n; k++)
                    send(load_item(pick_dim(), 1'b0));
                send(load_item(pick_dim(), 1'b1));
                send_queries(4, 2);
            end
            else
            begin
                n = $urandom_range(4, 1);
                for (k = 0; k < n; k++)
                begin
                    it = mco_pkg::item_t'(ITEM_W'({$urandom, $urandom}));
                    send(it);
                end
            end

            if ($urandom_range(9) == 0)
                await_answers();

            // Hold the result side while queries keep coming, then drain
            if (!held && items_sent > target - RANDOM_ITEMS / 2)
            begin
                held   = 1'b1;
                steady = 1'b0;
                run_chain(3);
                hold_req = 1'b1;
                for (k = 0; k < 12; k++)
                    send(query_item($urandom_range(3, 1), 3));
                await_answers();
            end
        end

        await_answers();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mco_pkg.sv
rtl/core/mco_ram.sv
rtl/core/mco_seq.sv
rtl/core/mco_datapath.sv
rtl/core/matrix_chain_order_dp_top.sv
verif/tb_matrix_chain_order_dp_top.sv
